>>> sv/gmc_pkg.sv
// Package for the gate motion controller: types, constants and register codes.
package gmc_pkg;

    localparam int TIMER_W    = 16;
    localparam int THRESH_W   = 16;
    localparam int DRIVE_W    = 12;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CMP_W      = (TIMER_W > THRESH_W) ? TIMER_W : THRESH_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_AUTO_CLOSE    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAUSE         = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DRIVE_OPENING = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DRIVE_CLOSING = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_DRIVE_STOP    = 3'd4;

    localparam logic [THRESH_W-1:0] AUTO_CLOSE_RST    = 16'd1000;
    localparam logic [THRESH_W-1:0] PAUSE_RST         = 16'd500;
    localparam logic [DRIVE_W-1:0]  DRIVE_OPENING_RST = 12'd400;
    localparam logic [DRIVE_W-1:0]  DRIVE_CLOSING_RST = 12'd200;
    localparam logic [DRIVE_W-1:0]  DRIVE_STOP_RST    = 12'd307;

    typedef enum logic [2:0] {
        ST_CLOSED        = 3'd0,
        ST_OPENING       = 3'd1,
        ST_OPEN          = 3'd2,
        ST_CLOSING       = 3'd3,
        ST_PAUSE_OPENING = 3'd4,
        ST_PAUSE_CLOSING = 3'd5
    } gate_state_t;

    typedef struct packed {
        logic open_limit_n;
        logic closed_limit_n;
        logic ir_blocked;
        logic remote_open;
        logic remote_close;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         gate_state;
        logic               drive_write;
        logic [DRIVE_W-1:0] drive_value;
    } out_item_t;

    typedef struct packed {
        logic [THRESH_W-1:0] auto_close_ticks;
        logic [THRESH_W-1:0] pause_ticks;
        logic [DRIVE_W-1:0]  drive_opening;
        logic [DRIVE_W-1:0]  drive_closing;
        logic [DRIVE_W-1:0]  drive_stop;
    } cfg_t;

endpackage

>>> sv/gmc_cfg.sv
// Configuration register file of the gate motion controller.
module gmc_cfg
    import gmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.auto_close_ticks <= AUTO_CLOSE_RST;
            cfg_reg.pause_ticks      <= PAUSE_RST;
            cfg_reg.drive_opening    <= DRIVE_OPENING_RST;
            cfg_reg.drive_closing    <= DRIVE_CLOSING_RST;
            cfg_reg.drive_stop       <= DRIVE_STOP_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_AUTO_CLOSE:    cfg_reg.auto_close_ticks <= cfg_data[THRESH_W-1:0];
                CFG_PAUSE:         cfg_reg.pause_ticks      <= cfg_data[THRESH_W-1:0];
                CFG_DRIVE_OPENING: cfg_reg.drive_opening    <= cfg_data[DRIVE_W-1:0];
                CFG_DRIVE_CLOSING: cfg_reg.drive_closing    <= cfg_data[DRIVE_W-1:0];
                CFG_DRIVE_STOP:    cfg_reg.drive_stop       <= cfg_data[DRIVE_W-1:0];
                default:           ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/gmc_fsm.sv
// Gate state machine: pending requests, timer and servo drive for one item a cycle while step is high.
module gmc_fsm
    import gmc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    gate_state_t        mode_reg, mode_next;
    logic [TIMER_W-1:0] elapsed_reg, elapsed_next;
    logic               open_pend_reg, open_pend_next;
    logic               close_pend_reg, close_pend_next;

    logic               open_req;
    logic               close_req;
    logic [TIMER_W-1:0] elapsed_inc;
    logic               auto_close_due;
    logic               pause_due;

    assign open_req    = open_pend_reg | item.remote_open;
    assign close_req   = close_pend_reg | item.remote_close;
    assign elapsed_inc = (elapsed_reg == {TIMER_W{1'b1}}) ? elapsed_reg
                                                          : elapsed_reg + 1'b1;
    assign auto_close_due = CMP_W'(elapsed_inc) >= CMP_W'(cfg.auto_close_ticks);
    assign pause_due      = CMP_W'(elapsed_inc) >= CMP_W'(cfg.pause_ticks);

    // next state
    always_comb
    begin
        mode_next       = mode_reg;
        elapsed_next    = elapsed_reg;
        open_pend_next  = open_req;
        close_pend_next = close_req;
        unique case (mode_reg)
            ST_CLOSED:
            begin
                if (open_req)
                begin
                    open_pend_next = 1'b0;
                    mode_next      = ST_OPENING;
                end
            end
            ST_OPEN:
            begin
                if (close_req)
                begin
                    close_pend_next = 1'b0;
                    mode_next       = ST_CLOSING;
                end
                else
                begin
                    elapsed_next = elapsed_inc;
                    if (auto_close_due)
                        mode_next = ST_CLOSING;
                end
            end
            ST_OPENING:
            begin
                if (item.ir_blocked)
                begin
                    mode_next    = ST_PAUSE_OPENING;
                    elapsed_next = '0;
                end
                else if (!item.open_limit_n)
                begin
                    mode_next    = ST_OPEN;
                    elapsed_next = '0;
                end
            end
            ST_CLOSING:
            begin
                if (item.ir_blocked)
                begin
                    mode_next    = ST_PAUSE_CLOSING;
                    elapsed_next = '0;
                end
                else if (!item.closed_limit_n)
                    mode_next = ST_CLOSED;
            end
            ST_PAUSE_OPENING, ST_PAUSE_CLOSING:
            begin
                if (item.ir_blocked)
                    elapsed_next = '0;
                else
                begin
                    elapsed_next = elapsed_inc;
                    if (pause_due)
                        mode_next = ST_OPENING;
                end
            end
            default:
                mode_next = ST_CLOSED;
        endcase
    end

    // outputs
    always_comb
    begin
        result.gate_state  = mode_next;
        result.drive_write = 1'b0;
        result.drive_value = '0;
        unique case (mode_reg)
            ST_OPENING:
            begin
                result.drive_write = 1'b1;
                result.drive_value = (item.ir_blocked || !item.open_limit_n)
                                     ? cfg.drive_stop : cfg.drive_opening;
            end
            ST_CLOSING:
            begin
                result.drive_write = 1'b1;
                result.drive_value = (item.ir_blocked || !item.closed_limit_n)
                                     ? cfg.drive_stop : cfg.drive_closing;
            end
            default:
            begin
                result.drive_write = 1'b0;
                result.drive_value = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= ST_CLOSED;
            elapsed_reg    <= '0;
            open_pend_reg  <= 1'b0;
            close_pend_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg       <= mode_next;
            elapsed_reg    <= elapsed_next;
            open_pend_reg  <= open_pend_next;
            close_pend_reg <= close_pend_next;
        end
    end

endmodule

>>> sv/gate_motion_controller_unit.sv
// Top level of the gate motion controller: input stage, state machine, result stage.
//
// One input item is one control tick: limit switches (active low), IR barrier
// and remote open/close requests. Every item gives exactly one result item with
// the gate state after the tick and any servo drive write.
// Both channels use valid/stall; an item moves on an edge with valid high and
// stall low. Configuration registers are written through cfg_wr_en, cfg_addr
// and cfg_data; the user must write them only while no item is in flight, as
// the block does not enforce this. An accepted item waits in the input
// register, which feeds the state update that loads the result register.
// Throughput: one item every cycle while out_stall is low; one FSM update per item.
// When the receiver stalls, the result register holds, the input register
// fills, and in_stall rises only once both are full.
// Reset (rst_n, asynchronous, active low) empties both stages, puts the gate
// in closed with the timer and pending requests clear, and loads the default
// thresholds and drive values.
module gate_motion_controller_unit
    import gmc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_item,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg;
    out_item_t result;

    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      s1_adv;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;

    gmc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gmc_fsm u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (s1_adv),
        .item   (s1_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                s1_valid_reg <= in_valid;
            if (!out_valid_reg || !out_stall)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_item_reg <= in_item;
        if (s1_adv)
            out_item_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTH
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a full pipeline");

    a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("advanced item did not reach the result register");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_item.drive_write) |-> (out_item.drive_value == '0))
        else $error("drive value set without a drive write");

    a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.gate_state <= 3'd5))
        else $error("unreachable gate state reported");
`endif

endmodule

>>> test/tb_gate_motion_controller_unit.sv
// Testbench for the gate motion controller: directed and random ticks against a predictor.
module tb_gate_motion_controller_unit
    import gmc_pkg::*;
;

    localparam int CYCLE_LIMIT = 200000;
    localparam int N_PHASES    = 6;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        in_item_t             tick;
        bit                   typed;
        out_item_t            want;
    } step_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_item;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    // side channel travelling with each item: hand-typed expectation
    logic      in_typed;
    out_item_t in_want;

    // predictor state and register copy
    gate_state_t         gate_mode;
    logic [TIMER_W-1:0]  gate_timer;
    logic                open_pend;
    logic                close_pend;
    cfg_t                regs;

    out_item_t gate_results_due[$];
    int        err_cnt = 0;
    int        ticks_sent = 0;
    int        results_seen = 0;
    int        settings_used = 0;
    int        cycles = 0;

    bit tx_up = 1'b0;
    bit tx_eager = 1'b0;
    bit rx_eager = 1'b0;
    int tx_gap = 0;
    int rx_hold_cycles = 0;

    gate_motion_controller_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic out_item_t gate_predict(in_item_t t);
        out_item_t          r;
        logic               wrote;
        logic [DRIVE_W-1:0] val;
        wrote = 1'b0;
        val = '0;
        if (t.remote_open)
            open_pend = 1'b1;
        if (t.remote_close)
            close_pend = 1'b1;
        case (gate_mode)
            ST_CLOSED:
                if (open_pend)
                begin
                    open_pend = 1'b0;
                    gate_mode = ST_OPENING;
                end
            ST_OPEN:
                if (close_pend)
                begin
                    close_pend = 1'b0;
                    gate_mode = ST_CLOSING;
                end
                else
                begin
                    if (~&gate_timer)
                        gate_timer = gate_timer + 1'b1;
                    if (gate_timer >= regs.auto_close_ticks)
                        gate_mode = ST_CLOSING;
                end
            ST_OPENING:
            begin
                wrote = 1'b1;
                val = regs.drive_opening;
                if (t.ir_blocked)
                begin
                    gate_mode = ST_PAUSE_OPENING;
                    gate_timer = '0;
                    val = regs.drive_stop;
                end
                else if (!t.open_limit_n)
                begin
                    gate_mode = ST_OPEN;
                    gate_timer = '0;
                    val = regs.drive_stop;
                end
            end
            ST_CLOSING:
            begin
                wrote = 1'b1;
                val = regs.drive_closing;
                if (t.ir_blocked)
                begin
                    gate_mode = ST_PAUSE_CLOSING;
                    gate_timer = '0;
                    val = regs.drive_stop;
                end
                else if (!t.closed_limit_n)
                begin
                    gate_mode = ST_CLOSED;
                    val = regs.drive_stop;
                end
            end
            ST_PAUSE_OPENING, ST_PAUSE_CLOSING:
                if (t.ir_blocked)
                    gate_timer = '0;
                else
                begin
                    if (~&gate_timer)
                        gate_timer = gate_timer + 1'b1;
                    if (gate_timer >= regs.pause_ticks)
                        gate_mode = ST_OPENING;
                end
            default:
                gate_mode = ST_CLOSED;
        endcase
        r.gate_state = gate_mode;
        r.drive_write = wrote;
        r.drive_value = wrote ? val : '0;
        return r;
    endfunction

    // result check first, then the prediction for a newly accepted tick
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (gate_results_due.size() == 0)
            begin
                $error("result with nothing expected: state %0d write %0d value %0d",
                       out_item.gate_state, out_item.drive_write, out_item.drive_value);
                err_cnt++;
            end
            else
            begin
                want = gate_results_due.pop_front();
                if (out_item.gate_state !== want.gate_state)
                begin
                    $error("gate_state: expected %0d, got %0d",
                           want.gate_state, out_item.gate_state);
                    err_cnt++;
                end
                if (out_item.drive_write !== want.drive_write)
                begin
                    $error("drive_write: expected %0d, got %0d",
                           want.drive_write, out_item.drive_write);
                    err_cnt++;
                end
                if (out_item.drive_value !== want.drive_value)
                begin
                    $error("drive_value: expected %0d, got %0d",
                           want.drive_value, out_item.drive_value);
                    err_cnt++;
                end
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            want = gate_predict(in_item);
            gate_results_due.push_back(in_typed ? in_want : want);
        end
    end

    // receiver: random stall per item, one long hold-off on request
    initial
    begin
        int n;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_cycles != 0)
            begin
                out_stall <= 1'b1;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end
            else
            begin
                n = rx_eager ? 0 : $urandom_range(0, 16);
                if (n != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    task automatic send_tick(in_item_t t, bit typed, out_item_t want);
        if (tx_gap > 0)
        begin
            if (tx_up)
            begin
                in_valid <= 1'b0;
                tx_up = 1'b0;
            end
            repeat (tx_gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        tx_up = 1'b1;
        in_item <= t;
        in_typed <= typed;
        in_want <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        ticks_sent++;
        tx_gap = tx_eager ? 0 : $urandom_range(0, 16);
    endtask

    task automatic wait_drained();
        if (tx_up)
        begin
            in_valid <= 1'b0;
            tx_up = 1'b0;
        end
        @(negedge clk);
        while (gate_results_due.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_AUTO_CLOSE:    regs.auto_close_ticks = val;
            CFG_PAUSE:         regs.pause_ticks = val;
            CFG_DRIVE_OPENING: regs.drive_opening = val[DRIVE_W-1:0];
            CFG_DRIVE_CLOSING: regs.drive_closing = val[DRIVE_W-1:0];
            CFG_DRIVE_STOP:    regs.drive_stop = val[DRIVE_W-1:0];
            default:           ;
        endcase
        @(posedge clk);
    endtask

    function automatic in_item_t rand_tick();
        in_item_t t;
        if ($urandom_range(0, 9) == 0)
            t = in_item_t'($urandom);
        else
        begin
            t.open_limit_n = ($urandom_range(0, 5) != 0);
            t.closed_limit_n = ($urandom_range(0, 5) != 0);
            t.ir_blocked = ($urandom_range(0, 7) == 0);
            t.remote_open = ($urandom_range(0, 9) == 0);
            t.remote_close = ($urandom_range(0, 11) == 0);
        end
        return t;
    endfunction

    function automatic step_t tick_row(bit ol, bit cl, bit ir, bit ro, bit rc);
        step_t s;
        s.is_cfg = 1'b0;
        s.reg_idx = CFG_AUTO_CLOSE;
        s.reg_val = '0;
        s.tick = '{ol, cl, ir, ro, rc};
        s.typed = 1'b0;
        s.want = '0;
        return s;
    endfunction

    function automatic step_t tick_chk(bit ol, bit cl, bit ir, bit ro, bit rc,
                                       gate_state_t st, bit w, logic [DRIVE_W-1:0] v);
        step_t s;
        s = tick_row(ol, cl, ir, ro, rc);
        s.typed = 1'b1;
        s.want.gate_state = st;
        s.want.drive_write = w;
        s.want.drive_value = v;
        return s;
    endfunction

    function automatic step_t cfg_row(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        step_t s;
        s = tick_row(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        s.is_cfg = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    initial
    begin
        step_t script[$];
        cfg_t  phase_cfg [N_PHASES];
        int    phase_len [N_PHASES];
        cfg_t  setting;

        rst_n = 1'b0;
        in_valid <= 1'b0;
        in_item <= '0;
        in_typed <= 1'b0;
        in_want <= '0;
        cfg_wr_en <= 1'b0;
        cfg_addr <= CFG_AUTO_CLOSE;
        cfg_data <= '0;

        gate_mode = ST_CLOSED;
        gate_timer = '0;
        open_pend = 1'b0;
        close_pend = 1'b0;
        regs = '{AUTO_CLOSE_RST, PAUSE_RST, DRIVE_OPENING_RST, DRIVE_CLOSING_RST,
                 DRIVE_STOP_RST};

        // ticks: open_limit_n, closed_limit_n, ir_blocked, remote_open, remote_close
        script.push_back(tick_chk(1, 1, 0, 0, 0, ST_CLOSED, 0, 12'd0));
        // limit switches are ignored while closed
        script.push_back(tick_chk(0, 0, 0, 0, 0, ST_CLOSED, 0, 12'd0));
        // both requests: open taken now, close stays latched
        script.push_back(tick_chk(1, 1, 0, 1, 1, ST_OPENING, 0, 12'd0));
        script.push_back(tick_chk(1, 1, 0, 0, 0, ST_OPENING, 1, 12'd400));
        // barrier wins over open limit
        script.push_back(tick_chk(0, 1, 1, 0, 0, ST_PAUSE_OPENING, 1, 12'd307));
        script.push_back(tick_chk(0, 0, 1, 0, 0, ST_PAUSE_OPENING, 0, 12'd0));
        script.push_back(tick_chk(1, 1, 0, 0, 0, ST_PAUSE_OPENING, 0, 12'd0));
        script.push_back(cfg_row(CFG_PAUSE, 16'd0));
        script.push_back(cfg_row(CFG_AUTO_CLOSE, 16'd0));
        script.push_back(tick_row(1, 1, 0, 0, 0));
        script.push_back(tick_row(0, 1, 0, 0, 0));
        // stale close request ends the open state at once
        script.push_back(tick_row(1, 1, 0, 0, 0));
        script.push_back(tick_row(1, 1, 0, 0, 0));
        // barrier wins over closed limit
        script.push_back(tick_chk(1, 0, 1, 0, 0, ST_PAUSE_CLOSING, 1, 12'd307));
        script.push_back(tick_row(1, 1, 1, 0, 0));
        script.push_back(tick_row(1, 1, 0, 0, 0));
        script.push_back(cfg_row(CFG_DRIVE_OPENING, 16'd4095));
        script.push_back(cfg_row(CFG_DRIVE_CLOSING, 16'd0));
        script.push_back(cfg_row(CFG_DRIVE_STOP, 16'd4095));
        script.push_back(tick_chk(1, 1, 0, 0, 0, ST_OPENING, 1, 12'd4095));
        script.push_back(tick_chk(0, 1, 0, 0, 0, ST_OPEN, 1, 12'd4095));
        // zero auto-close fires on first open tick
        script.push_back(tick_row(1, 1, 0, 0, 0));
        script.push_back(tick_chk(1, 1, 0, 0, 0, ST_CLOSING, 1, 12'd0));
        script.push_back(tick_chk(1, 0, 0, 0, 0, ST_CLOSED, 1, 12'd4095));
        script.push_back(tick_row(1, 1, 0, 0, 1));
        script.push_back(tick_row(1, 1, 0, 1, 0));
        script.push_back(cfg_row(CFG_AUTO_CLOSE, 16'd65535));
        script.push_back(tick_row(0, 1, 0, 0, 0));
        script.push_back(tick_row(1, 1, 0, 0, 0));
        script.push_back(tick_row(1, 1, 0, 0, 0));
        script.push_back(tick_row(1, 0, 0, 0, 0));

        phase_cfg[0] = '{16'd3, 16'd2, 12'd4095, 12'd0, 12'd2048};
        phase_cfg[1] = '{16'd0, 16'd0, 12'd0, 12'd4095, 12'd0};
        phase_cfg[2] = '{16'd65535, 16'd65535, 12'd1365, 12'd2730, 12'd4095};
        phase_cfg[3] = '{16'd6, 16'd4, 12'd0, 12'd0, 12'd0};
        phase_cfg[4] = '{16'd1, 16'd1, 12'd0, 12'd0, 12'd0};
        phase_cfg[5] = '{16'd20, 16'd8, 12'd0, 12'd0, 12'd0};
        phase_len = '{90, 80, 60, 100, 90, 90};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[k])
        begin
            if (script[k].is_cfg)
            begin
                wait_drained();
                write_reg(script[k].reg_idx, script[k].reg_val);
            end
            else
                send_tick(script[k].tick, script[k].typed, script[k].want);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            setting = phase_cfg[p];
            if (p >= 3)
            begin
                setting.drive_opening = DRIVE_W'($urandom_range(0, 4095));
                setting.drive_closing = DRIVE_W'($urandom_range(0, 4095));
                setting.drive_stop = DRIVE_W'($urandom_range(0, 4095));
            end
            wait_drained();
            write_reg(CFG_AUTO_CLOSE, setting.auto_close_ticks);
            write_reg(CFG_PAUSE, setting.pause_ticks);
            write_reg(CFG_DRIVE_OPENING, CFG_DATA_W'(setting.drive_opening));
            write_reg(CFG_DRIVE_CLOSING, CFG_DATA_W'(setting.drive_closing));
            write_reg(CFG_DRIVE_STOP, CFG_DATA_W'(setting.drive_stop));
            settings_used++;
            for (int i = 0; i < phase_len[p]; i++)
            begin
                // back-to-back ticks into a held-off receiver fill the pipeline
                if (p == 0 && i == 0)
                begin
                    tx_eager = 1'b1;
                    tx_gap = 0;
                    rx_hold_cycles = 150;
                end
                if (p == 0 && i == 40)
                    tx_eager = 1'b0;
                if (p == 1 && i == 20)
                begin
                    tx_eager = 1'b1;
                    tx_gap = 0;
                    rx_eager = 1'b1;
                end
                if (p == 1 && i == 50)
                begin
                    tx_eager = 1'b0;
                    rx_eager = 1'b0;
                end
                if (i == phase_len[p] / 2)
                    wait_drained();
                send_tick(rand_tick(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        $display("Sent %0d ticks over %0d random register settings plus directed cases;",
                 ticks_sent, settings_used);
        $display("%0d results compared, %0d mismatches.", results_seen, err_cnt);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
sv/gmc_pkg.sv
sv/gmc_cfg.sv
sv/gmc_fsm.sv
sv/gate_motion_controller_unit.sv
test/tb_gate_motion_controller_unit.sv
